/* rtl/core/crq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crq_pkg
// Shared types, sizes and operation codes of the credit request queue.
// ----------------------------------------------------------------------------
package crq_pkg;

    // Storage geometry
    localparam int DEPTH     = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int ADDR_BITS = 32;
    localparam int LIMIT_W   = 5;
    // entries + reserved + 1 never needs more than this
    localparam int SUM_W     = LIMIT_W + 2;

    localparam logic [LIMIT_W-1:0] MAX_SIZE_RESET = LIMIT_W'(16);

    // Operation codes
    localparam logic [2:0] OP_RESERVE  = 3'd0;
    localparam logic [2:0] OP_RELEASE  = 3'd1;
    localparam logic [2:0] OP_ALLOCATE = 3'd2;
    localparam logic [2:0] OP_ERASE    = 3'd3;
    localparam logic [2:0] OP_CONFLICT = 3'd4;
    localparam logic [2:0] OP_FIND     = 3'd5;
    localparam logic [2:0] OP_GET      = 3'd6;
    localparam logic [2:0] OP_CLEAR    = 3'd7;

    // Request beat
    typedef struct packed {
        logic [2:0]           req_type;
        logic [7:0]           entry_tag;
        logic [ADDR_BITS-1:0] block_address;
        logic [3:0]           request_kind;
        logic [3:0]           bank;
        logic [3:0]           position;
    } req_t;

    // Result beat
    typedef struct packed {
        logic         hit;
        logic [7:0]   found_tag;
        logic [3:0]   found_index;
        logic [4:0]   queue_size;
        logic [4:0]   reserved_count;
        logic [4:0]   available;
        logic         has_credit;
        logic         is_empty;
        logic         credit_error;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture request and match vector
        logic exec;   // resolve match, update state, emit result
    } cmd_t;

endpackage

/* rtl/core/crq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crq_ctrl
// Two-state sequencer: capture a request, then execute it.
// ----------------------------------------------------------------------------
module crq_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output crq_pkg::cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands to the datapath
    assign busy     = (state_reg == ST_EXEC);
    assign cmd.load = (state_reg == ST_IDLE) && start;
    assign cmd.exec = (state_reg == ST_EXEC);

endmodule

/* rtl/core/crq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crq_datapath
// Entry storage, parallel match, credit counters and result register.
// ----------------------------------------------------------------------------
module crq_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  crq_pkg::cmd_t                  cmd,
    input  crq_pkg::req_t                  req,
    input  logic                           cfg_we,
    input  logic [crq_pkg::LIMIT_W-1:0]    cfg_wdata,
    output logic                           done,
    output crq_pkg::rsp_t                  rsp
);

    // Entry storage (no reset: only entries below the count are read)
    logic [7:0]                    tag_reg  [crq_pkg::DEPTH];
    logic [crq_pkg::ADDR_BITS-1:0] addr_reg [crq_pkg::DEPTH];
    logic [3:0]                    kind_reg [crq_pkg::DEPTH];
    logic [3:0]                    bank_reg [crq_pkg::DEPTH];

    logic [crq_pkg::CNT_W-1:0]   count_reg;
    logic [crq_pkg::CNT_W-1:0]   count_next;
    logic [crq_pkg::LIMIT_W-1:0] rsv_reg;
    logic [crq_pkg::LIMIT_W-1:0] rsv_next;
    logic [crq_pkg::LIMIT_W-1:0] max_reg;

    crq_pkg::req_t             req_reg;
    logic [crq_pkg::DEPTH-1:0] match_reg;
    logic [crq_pkg::DEPTH-1:0] match_next;

    logic          done_reg;
    crq_pkg::rsp_t rsp_reg;
    crq_pkg::rsp_t rsp_next;

    logic                        hit;
    logic                        err;
    logic                        any_match;
    logic [crq_pkg::IDX_W-1:0]   first_idx;
    logic [crq_pkg::IDX_W-1:0]   sel_idx;
    logic                        pos_ok;
    logic                        do_alloc;
    logic                        do_erase;
    logic [crq_pkg::SUM_W-1:0]   used_now;
    logic [crq_pkg::SUM_W-1:0]   used_new;
    logic [crq_pkg::SUM_W-1:0]   limit_ext;

    // Compare all valid entries against the incoming beat
    always_comb
    begin
        for (int i = 0; i < crq_pkg::DEPTH; i++)
        begin
            match_next[i] = 1'b0;
            if (crq_pkg::CNT_W'(i) < count_reg)
            begin
                case (req.req_type)
                    crq_pkg::OP_ERASE:
                        match_next[i] = (tag_reg[i] == req.entry_tag);
                    crq_pkg::OP_CONFLICT:
                        match_next[i] = (addr_reg[i] == req.block_address);
                    crq_pkg::OP_FIND:
                        match_next[i] = (kind_reg[i] == req.request_kind) &&
                                        (bank_reg[i] == req.bank);
                    default:
                        match_next[i] = 1'b0;
                endcase
            end
        end
    end

    // Oldest match
    always_comb
    begin
        first_idx = '0;
        for (int i = crq_pkg::DEPTH - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                first_idx = crq_pkg::IDX_W'(i);
            end
        end
    end

    assign any_match = |match_reg;
    assign pos_ok    = ({1'b0, req_reg.position} < count_reg);
    assign limit_ext = crq_pkg::SUM_W'(max_reg);
    assign used_now  = crq_pkg::SUM_W'(count_reg) + crq_pkg::SUM_W'(rsv_reg);

    // Operation execute
    always_comb
    begin
        count_next = count_reg;
        rsv_next   = rsv_reg;
        hit        = 1'b0;
        err        = 1'b0;
        do_alloc   = 1'b0;
        do_erase   = 1'b0;
        sel_idx    = first_idx;
        unique case (req_reg.req_type) inside
            crq_pkg::OP_RESERVE:
            begin
                if (used_now + crq_pkg::SUM_W'(1) > limit_ext)
                    err = 1'b1;
                else
                    rsv_next = rsv_reg + crq_pkg::LIMIT_W'(1);
            end
            crq_pkg::OP_RELEASE:
            begin
                if ((rsv_reg == '0) || (used_now - crq_pkg::SUM_W'(1) > limit_ext))
                    err = 1'b1;
                else
                    rsv_next = rsv_reg - crq_pkg::LIMIT_W'(1);
            end
            crq_pkg::OP_ALLOCATE:
            begin
                if ((count_reg >= crq_pkg::CNT_W'(crq_pkg::DEPTH)) ||
                    (used_now + crq_pkg::SUM_W'(1) > limit_ext))
                begin
                    err = 1'b1;
                end
                else
                begin
                    do_alloc   = 1'b1;
                    count_next = count_reg + crq_pkg::CNT_W'(1);
                end
            end
            crq_pkg::OP_ERASE:
            begin
                hit = any_match;
                if (any_match)
                begin
                    do_erase   = 1'b1;
                    count_next = count_reg - crq_pkg::CNT_W'(1);
                end
            end
            crq_pkg::OP_CONFLICT, crq_pkg::OP_FIND:
            begin
                hit = any_match;
            end
            crq_pkg::OP_GET:
            begin
                hit     = pos_ok;
                sel_idx = req_reg.position[crq_pkg::IDX_W-1:0];
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    // Result beat
    assign used_new = crq_pkg::SUM_W'(count_next) + crq_pkg::SUM_W'(rsv_next);

    always_comb
    begin
        rsp_next.hit            = hit;
        rsp_next.found_tag      = hit ? tag_reg[sel_idx] : 8'd0;
        rsp_next.found_index    = hit ? 4'(sel_idx) : 4'd0;
        rsp_next.queue_size     = 5'(count_next);
        rsp_next.reserved_count = 5'(rsv_next);
        rsp_next.available      = (used_new < limit_ext) ?
                                  5'(limit_ext - used_new) : 5'd0;
        rsp_next.has_credit     = (used_new < limit_ext);
        rsp_next.is_empty       = (count_next == '0);
        rsp_next.credit_error   = err;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rsv_reg   <= '0;
            max_reg   <= crq_pkg::MAX_SIZE_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec;
            if (cfg_we)
            begin
                max_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                count_reg <= count_next;
                rsv_reg   <= rsv_next;
            end
        end
    end

    // Captured request, match vector and result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req;
            match_reg <= match_next;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Storage update: append at the tail, or shift down over the erased slot
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (do_alloc)
            begin
                tag_reg[count_reg[crq_pkg::IDX_W-1:0]]  <= req_reg.entry_tag;
                addr_reg[count_reg[crq_pkg::IDX_W-1:0]] <= req_reg.block_address;
                kind_reg[count_reg[crq_pkg::IDX_W-1:0]] <= req_reg.request_kind;
                bank_reg[count_reg[crq_pkg::IDX_W-1:0]] <= req_reg.bank;
            end
            else if (do_erase)
            begin
                for (int i = 0; i < crq_pkg::DEPTH - 1; i++)
                begin
                    if (crq_pkg::IDX_W'(i) >= first_idx)
                    begin
                        tag_reg[i]  <= tag_reg[i + 1];
                        addr_reg[i] <= addr_reg[i + 1];
                        kind_reg[i] <= kind_reg[i + 1];
                        bank_reg[i] <= bank_reg[i + 1];
                    end
                end
            end
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

/* rtl/core/credit_request_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// credit_request_queue
// Ordered request queue with credit accounting, in front of a cache bank.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. Every request
// passes a capture step and an execute step: the capture step compares the beat
// against all 16 entries in parallel and registers the match vector, the
// execute step picks the oldest match, updates the storage and counters and
// registers the result. The result beat appears on rsp with done high for
// exactly one cycle, the cycle after the execute step; there is no
// backpressure, so sample it then. A new request can be taken in the same
// cycle that done is high, but not while busy is high. max_size may be
// written through cfg_we/cfg_wdata only while no request is in flight.
// ----------------------------------------------------------------------------
module credit_request_queue
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  crq_pkg::req_t                  req,
    input  logic                           cfg_we,
    input  logic [crq_pkg::LIMIT_W-1:0]    cfg_wdata,
    output logic                           done,
    output crq_pkg::rsp_t                  rsp
);

    crq_pkg::cmd_t cmd;

    // Sequencer
    crq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Storage and result path
    crq_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .rsp       (rsp)
    );

endmodule
